FILE: design/wpc_pkg.sv
// shared types and constants for the weighted pearson correlation block
package wpc_pkg;

  // input transaction payload
  typedef struct packed {
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic [15:0]        weight;
    logic               last_sample;
  } in_t;

  // result transaction payload
  typedef struct packed {
    logic signed [15:0] correlation;
    logic [1:0]         status;
  } out_t;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_WEIGHT = 2'd1;
  localparam logic [1:0] ST_NO_VAR    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // accumulator widths
  localparam int SW_W  = 28;
  localparam int SX_W  = 44;
  localparam int SXX_W = 58;
  localparam int SXY_W = 59;
  localparam int XW_W  = 33;

  // shared multiplier: product width, multiplier width, bit count width
  localparam int PW  = 180;
  localparam int BW  = 90;
  localparam int NBW = 7;

  // root search width and fraction shift
  localparam int RW     = 212;
  localparam int Q_SHIFT = 30;

  // multiplier bit counts per operand class
  localparam logic [NBW-1:0] ITEM_BITS = NBW'(16);
  localparam logic [NBW-1:0] SW_BITS   = NBW'(28);
  localparam logic [NBW-1:0] SUM_BITS  = NBW'(44);
  localparam logic [NBW-1:0] WIDE_BITS = NBW'(88);

  // multiplier operations run by the sequencer
  localparam logic [3:0] OP_XW  = 4'd0;
  localparam logic [3:0] OP_YW  = 4'd1;
  localparam logic [3:0] OP_XXW = 4'd2;
  localparam logic [3:0] OP_YYW = 4'd3;
  localparam logic [3:0] OP_XYW = 4'd4;
  localparam logic [3:0] OP_NA  = 4'd5;
  localparam logic [3:0] OP_NB  = 4'd6;
  localparam logic [3:0] OP_XA  = 4'd7;
  localparam logic [3:0] OP_XB  = 4'd8;
  localparam logic [3:0] OP_YA  = 4'd9;
  localparam logic [3:0] OP_YB  = 4'd10;
  localparam logic [3:0] OP_DEN = 4'd11;
  localparam logic [3:0] OP_LHS = 4'd12;

endpackage

FILE: design/weighted_pearson_correlation.sv
// weighted pearson correlation: exact weighted sums, q1.15 result on the last sample
// an ordinary sample keeps busy high for five 16-bit products through the shared
// bit-serial multiplier and the check state; past MAX_SAMPLES the products are skipped
// a last sample adds up to eight products, the last two 88 bits wide, a variance check
// and a root search; valid pulses for one cycle as busy drops, no stall
// synchronous active-high reset clears all sums and the sample count; no clearing pass
module weighted_pearson_correlation #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  wpc_pkg::in_t   item,
  output logic           busy,
  output logic           valid,
  output wpc_pkg::out_t  result
);

  localparam int PW = wpc_pkg::PW;
  localparam int BW = wpc_pkg::BW;
  localparam int RW = wpc_pkg::RW;
  localparam int CW = $clog2(MAX_SAMPLES + 2);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_VCHK, S_RWAIT} state_t;

  state_t state;
  logic [3:0] op;

  // sums and count
  logic [wpc_pkg::SW_W-1:0]         sw;
  logic signed [wpc_pkg::SX_W-1:0]  sx;
  logic signed [wpc_pkg::SX_W-1:0]  sy;
  logic [wpc_pkg::SXX_W-1:0]        sxx;
  logic [wpc_pkg::SXX_W-1:0]        syy;
  logic signed [wpc_pkg::SXY_W-1:0] sxy;
  logic [CW-1:0]                    cnt;

  // held sample and intermediate terms
  logic signed [15:0]               xs;
  logic signed [15:0]               ys;
  logic [15:0]                      ws;
  logic                             last_r;
  logic signed [wpc_pkg::XW_W-1:0]  xw;
  logic signed [wpc_pkg::XW_W-1:0]  yw;
  logic signed [PW-1:0]             t1;
  logic signed [PW-1:0]             num;
  logic signed [PW-1:0]             dx;
  logic signed [PW-1:0]             dy;

  // multiplier and root unit hookup
  logic                        mul_start;
  logic signed [PW-1:0]        mul_a;
  logic signed [BW-1:0]        mul_b;
  logic [wpc_pkg::NBW-1:0]     mul_n;
  logic                        mul_done;
  logic signed [PW-1:0]        mul_p;
  logic                        root_start;
  logic [RW-1:0]               root_l;
  logic [RW-1:0]               root_d;
  logic                        root_done;
  logic [15:0]                 root_q;

  logic [16:0]                 q_clamp;
  logic signed [15:0]          corr_val;
  logic                        accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_n = wpc_pkg::ITEM_BITS;
    case (op)
      wpc_pkg::OP_XW: begin
        mul_a = PW'(xs);
        mul_b = BW'($signed({1'b0, ws}));
      end
      wpc_pkg::OP_YW: begin
        mul_a = PW'(ys);
        mul_b = BW'($signed({1'b0, ws}));
      end
      wpc_pkg::OP_XXW: begin
        mul_a = PW'(xw);
        mul_b = BW'(xs);
      end
      wpc_pkg::OP_YYW: begin
        mul_a = PW'(yw);
        mul_b = BW'(ys);
      end
      wpc_pkg::OP_XYW: begin
        mul_a = PW'(yw);
        mul_b = BW'(xs);
      end
      wpc_pkg::OP_NA: begin
        mul_a = PW'(sxy);
        mul_b = BW'($signed({1'b0, sw}));
        mul_n = wpc_pkg::SW_BITS;
      end
      wpc_pkg::OP_NB: begin
        mul_a = PW'(sx);
        mul_b = BW'(sy);
        mul_n = wpc_pkg::SUM_BITS;
      end
      wpc_pkg::OP_XA: begin
        mul_a = PW'($signed({1'b0, sxx}));
        mul_b = BW'($signed({1'b0, sw}));
        mul_n = wpc_pkg::SW_BITS;
      end
      wpc_pkg::OP_XB: begin
        mul_a = PW'(sx);
        mul_b = BW'(sx);
        mul_n = wpc_pkg::SUM_BITS;
      end
      wpc_pkg::OP_YA: begin
        mul_a = PW'($signed({1'b0, syy}));
        mul_b = BW'($signed({1'b0, sw}));
        mul_n = wpc_pkg::SW_BITS;
      end
      wpc_pkg::OP_YB: begin
        mul_a = PW'(sy);
        mul_b = BW'(sy);
        mul_n = wpc_pkg::SUM_BITS;
      end
      wpc_pkg::OP_DEN: begin
        mul_a = dx;
        mul_b = BW'(dy);
        mul_n = wpc_pkg::WIDE_BITS;
      end
      wpc_pkg::OP_LHS: begin
        mul_a = num;
        mul_b = BW'(num);
        mul_n = wpc_pkg::WIDE_BITS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start  = (state == S_ISSUE);
  assign root_start = (state == S_WAIT) && mul_done && (op == wpc_pkg::OP_LHS);
  assign root_l     = {{(RW - PW){1'b0}}, mul_p} << wpc_pkg::Q_SHIFT;
  assign root_d     = {{(RW - PW){1'b0}}, t1};

  // signed q1.15 from the root magnitude and the numerator sign
  always_comb begin
    q_clamp = (root_q > 16'd32768) ? 17'd32768 : {1'b0, root_q};
    if (num[PW-1]) begin
      corr_val = 16'(-q_clamp);
    end else if (q_clamp > 17'd32767) begin
      corr_val = 16'sd32767;
    end else begin
      corr_val = q_clamp[15:0];
    end
  end

  wpc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .nbits (mul_n),
    .done  (mul_done),
    .p     (mul_p)
  );

  wpc_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .l     (root_l),
    .d     (root_d),
    .done  (root_done),
    .q     (root_q)
  );

  // sequencer, sums and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op     <= wpc_pkg::OP_XW;
      valid  <= 1'b0;
      sw     <= '0;
      sx     <= '0;
      sy     <= '0;
      sxx    <= '0;
      syy    <= '0;
      sxy    <= '0;
      cnt    <= '0;
      last_r <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            xs     <= item.x_sample;
            ys     <= item.y_sample;
            ws     <= item.weight;
            last_r <= item.last_sample;
            if (cnt < CW'(MAX_SAMPLES)) begin
              cnt   <= cnt + 1'b1;
              sw    <= sw + wpc_pkg::SW_W'(item.weight);
              op    <= wpc_pkg::OP_XW;
              state <= S_ISSUE;
            end else begin
              cnt   <= CW'(MAX_SAMPLES + 1);
              state <= S_CHECK;
            end
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            case (op)
              wpc_pkg::OP_XW: begin
                xw <= wpc_pkg::XW_W'(mul_p);
                sx <= sx + wpc_pkg::SX_W'(mul_p);
              end
              wpc_pkg::OP_YW: begin
                yw <= wpc_pkg::XW_W'(mul_p);
                sy <= sy + wpc_pkg::SX_W'(mul_p);
              end
              wpc_pkg::OP_XXW: sxx <= sxx + wpc_pkg::SXX_W'(mul_p);
              wpc_pkg::OP_YYW: syy <= syy + wpc_pkg::SXX_W'(mul_p);
              wpc_pkg::OP_XYW: sxy <= sxy + wpc_pkg::SXY_W'(mul_p);
              wpc_pkg::OP_NA:  t1  <= mul_p;
              wpc_pkg::OP_NB:  num <= t1 - mul_p;
              wpc_pkg::OP_XA:  t1  <= mul_p;
              wpc_pkg::OP_XB:  dx  <= t1 - mul_p;
              wpc_pkg::OP_YA:  t1  <= mul_p;
              wpc_pkg::OP_YB:  dy  <= t1 - mul_p;
              wpc_pkg::OP_DEN: t1  <= mul_p;
              default: ;
            endcase
            case (op)
              wpc_pkg::OP_XYW: state <= S_CHECK;
              wpc_pkg::OP_YB:  state <= S_VCHK;
              wpc_pkg::OP_LHS: state <= S_RWAIT;
              default: begin
                op    <= op + 1'b1;
                state <= S_ISSUE;
              end
            endcase
          end
        end
        S_CHECK: begin
          // end of an item: report only on the last one
          if (!last_r) begin
            state <= S_IDLE;
          end else if (cnt > CW'(MAX_SAMPLES)) begin
            result.correlation <= '0;
            result.status      <= wpc_pkg::ST_OVERFLOW;
            valid              <= 1'b1;
            state              <= S_IDLE;
          end else if (sw == '0) begin
            result.correlation <= '0;
            result.status      <= wpc_pkg::ST_NO_WEIGHT;
            valid              <= 1'b1;
            state              <= S_IDLE;
          end else begin
            op    <= wpc_pkg::OP_NA;
            state <= S_ISSUE;
          end
          if (last_r) begin
            if ((cnt > CW'(MAX_SAMPLES)) || (sw == '0)) begin
              sw  <= '0;
              sx  <= '0;
              sy  <= '0;
              sxx <= '0;
              syy <= '0;
              sxy <= '0;
              cnt <= '0;
            end
          end
        end
        S_VCHK: begin
          // a variance term that is zero or negative ends the set
          if (dx[PW-1] || (dx == '0) || dy[PW-1] || (dy == '0)) begin
            result.correlation <= '0;
            result.status      <= wpc_pkg::ST_NO_VAR;
            valid              <= 1'b1;
            state              <= S_IDLE;
            sw                 <= '0;
            sx                 <= '0;
            sy                 <= '0;
            sxx                <= '0;
            syy                <= '0;
            sxy                <= '0;
            cnt                <= '0;
          end else begin
            op    <= wpc_pkg::OP_DEN;
            state <= S_ISSUE;
          end
        end
        S_RWAIT: begin
          if (root_done) begin
            result.correlation <= corr_val;
            result.status      <= wpc_pkg::ST_OK;
            valid              <= 1'b1;
            state              <= S_IDLE;
            sw                 <= '0;
            sx                 <= '0;
            sy                 <= '0;
            sxx                <= '0;
            syy                <= '0;
            sxy                <= '0;
            cnt                <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result always leaves the block idle with its sums cleared
  assert property (@(posedge clk) disable iff (rst)
    valid |-> (!busy && (sw == '0) && (cnt == '0)))
    else $error("result without cleared state");

  // error results carry a zero correlation
  assert property (@(posedge clk) disable iff (rst)
    (valid && (result.status != wpc_pkg::ST_OK)) |-> (result.correlation == '0))
    else $error("nonzero correlation on error status");

  // multiplier completes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_WAIT))
    else $error("unexpected multiplier completion");

  // the sample count never passes the overflow mark
  assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SAMPLES + 1))
    else $error("sample count out of range");

endmodule

FILE: design/wpc_mul.sv
// bit-serial signed shift-and-add multiplier shared by all products
module wpc_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [wpc_pkg::PW-1:0] a,
  input  logic signed [wpc_pkg::BW-1:0] b,
  input  logic [wpc_pkg::NBW-1:0]       nbits,
  output logic                          done,
  output logic signed [wpc_pkg::PW-1:0] p
);

  localparam int NBW = wpc_pkg::NBW;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

  mstate_t                       state;
  logic signed [wpc_pkg::PW-1:0] acc;
  logic signed [wpc_pkg::PW-1:0] mcand;
  logic [wpc_pkg::BW-1:0]        mplier;
  logic [wpc_pkg::NBW-1:0]       cnt;
  logic                          neg;

  // one multiplier bit per cycle, sign fixed up at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            acc    <= '0;
            mcand  <= a;
            mplier <= b[wpc_pkg::BW-1] ? (-b) : b;
            neg    <= b[wpc_pkg::BW-1];
            cnt    <= nbits;
            state  <= M_RUN;
          end
        end
        M_RUN: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt <= NBW'(1)) begin
            state <= M_FIX;
          end
        end
        M_FIX: begin
          p     <= neg ? (-acc) : acc;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: design/wpc_root.sv
// bit-at-a-time search for the largest q with q*q*d <= l, shifts, adds and subtracts only
module wpc_root (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [wpc_pkg::RW-1:0] l,
  input  logic [wpc_pkg::RW-1:0] d,
  output logic                   done,
  output logic [15:0]            q
);

  logic                   run;
  logic [3:0]             bit_idx;
  logic [wpc_pkg::RW-1:0] rem;
  logic [wpc_pkg::RW-1:0] esh;
  logic [wpc_pkg::RW-1:0] dsh;
  logic [wpc_pkg::RW-1:0] trial;
  logic                   fits;

  // trial term (2q*2^b + 2^2b) * d held as shifted copies
  assign trial = esh + dsh;
  assign fits  = (trial <= rem);

  // one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= l;
        esh     <= '0;
        dsh     <= d << wpc_pkg::Q_SHIFT;
        q       <= '0;
        bit_idx <= 4'd15;
        run     <= 1'b1;
      end else if (run) begin
        if (fits) begin
          rem        <= rem - trial;
          esh        <= (esh >> 1) + dsh;
          q[bit_idx] <= 1'b1;
        end else begin
          esh <= esh >> 1;
        end
        dsh     <= dsh >> 2;
        bit_idx <= bit_idx - 1'b1;
        if (bit_idx == 4'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
// testbench for the weighted pearson correlation block: exact predictor and scoreboard
`timescale 1ns / 100ps

module tb;

  localparam int MAX_SAMPLES = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  wpc_pkg::in_t item = '0;
  logic busy;
  logic valid;
  wpc_pkg::out_t result;

  weighted_pearson_correlation #(.MAX_SAMPLES(MAX_SAMPLES)) DUT (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .valid(valid), .result(result)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wpc_pkg::in_t pending_items[$];
  wpc_pkg::out_t corr_expect_q[$];
  int send_idle_pct = 0;
  bit took = 1'b0;
  int mismatches = 0;

  // running weighted sums, held in 64-bit longints wide enough for the block's sums
  longint unsigned sum_w, sum_xx, sum_yy;
  longint sum_x, sum_y, sum_xy;
  int n_held;

  function automatic void clear_sums();
    sum_w = 0; sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0; n_held = 0;
  endfunction

  // fold one sample in; on the last sample return the expected result
  function automatic bit fold_sample(wpc_pkg::in_t s, output wpc_pkg::out_t r);
    longint x, y, w;
    logic signed [255:0] sw, sx, sy, sxx, syy, sxy, num, dx, dy, mag, lhs, den, c2;
    logic [15:0] q, cand;
    x = s.x_sample;
    y = s.y_sample;
    w = longint'(s.weight);
    if (n_held < MAX_SAMPLES) begin
      sum_w += w;
      sum_x += x * w;
      sum_y += y * w;
      sum_xx += x * x * w;
      sum_yy += y * y * w;
      sum_xy += x * y * w;
      n_held++;
    end else begin
      n_held = MAX_SAMPLES + 1;
    end
    if (!s.last_sample) return 1'b0;
    r.correlation = '0;
    if (n_held > MAX_SAMPLES) begin
      r.status = wpc_pkg::ST_OVERFLOW;
    end else if (sum_w == 0) begin
      r.status = wpc_pkg::ST_NO_WEIGHT;
    end else begin
      sw = $signed({1'b0, sum_w});
      sx = sum_x;
      sy = sum_y;
      sxx = $signed({1'b0, sum_xx});
      syy = $signed({1'b0, sum_yy});
      sxy = sum_xy;
      num = sxy * sw - sx * sy;
      dx = sxx * sw - sx * sx;
      dy = syy * sw - sy * sy;
      if (dx <= 0 || dy <= 0) begin
        r.status = wpc_pkg::ST_NO_VAR;
      end else begin
        r.status = wpc_pkg::ST_OK;
        mag = (num < 0) ? -num : num;
        lhs = (mag * mag) <<< wpc_pkg::Q_SHIFT;
        den = dx * dy;
        // bitwise root search for the largest q with q^2*dx*dy <= num^2*2^30
        q = 0;
        for (int b = 15; b >= 0; b--) begin
          cand = q | (16'd1 << b);
          c2 = $signed({1'b0, 32'(cand) * 32'(cand)});
          if (c2 * den <= lhs) q = cand;
        end
        // magnitude never exceeds 1.0
        if (q > 16'd32768) q = 16'd32768;
        if (num < 0) r.correlation = 16'(-$signed({1'b0, q}));
        else r.correlation = (q > 16'd32767) ? 16'sd32767 : $signed(q);
      end
    end
    clear_sums();
    return 1'b1;
  endfunction

  // driver: present the next transaction at the falling edge
  always @(negedge clk) begin
    logic s_next;
    wpc_pkg::in_t i_next;
    s_next = start;
    i_next = item;
    if (!rst && (!start || took)) begin
      s_next = 1'b0;
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        i_next = pending_items.pop_front();
        s_next = 1'b1;
      end
    end
    start <= s_next;
    item <= i_next;
  end

  // monitor: check results and predict on accepted transactions
  always @(posedge clk) begin
    wpc_pkg::out_t exp_r;
    if (!rst) begin
      took <= (start && !busy);
      if (valid) begin
        if (corr_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result corr=%0d status=%0d",
                                         result.correlation, result.status);
        end else begin
          exp_r = corr_expect_q.pop_front();
          if (exp_r.correlation !== result.correlation || exp_r.status !== result.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected corr=%0d status=%0d, got corr=%0d status=%0d",
                       exp_r.correlation, exp_r.status, result.correlation, result.status);
          end
        end
      end
      if (start && !busy) begin
        if (fold_sample(item, exp_r)) corr_expect_q.push_back(exp_r);
      end
    end
  end

  function automatic wpc_pkg::in_t mk(int x, int y, int w, bit l);
    wpc_pkg::in_t s;
    s.x_sample = 16'(x);
    s.y_sample = 16'(y);
    s.weight = 16'(w);
    s.last_sample = l;
    return s;
  endfunction

  // random set: mostly well-formed data with mixed flavors
  task automatic push_random_set();
    int n, kind, x, y;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
    kind = $urandom_range(4);
    for (int k = 0; k < n; k++) begin
      x = $urandom_range(65535) - 32768;
      case (kind)
        0: y = $urandom_range(65535) - 32768;
        1: y = x + $urandom_range(200) - 100;
        2: y = -x + $urandom_range(4000) - 2000;
        3: begin
          x = $urandom_range(20) - 10;
          y = $urandom_range(20) - 10;
        end
        default: y = x;
      endcase
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      pending_items.push_back(mk(x, y, ($urandom_range(7) == 0) ? 0 : $urandom_range(65535),
                                 k == n - 1));
    end
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !start && corr_expect_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int sent;
    clear_sums();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, perfect correlation both signs, each status but overflow
    pending_items.push_back(mk(-32768, -32768, 65535, 0));
    pending_items.push_back(mk(32767, 32767, 65535, 1));
    pending_items.push_back(mk(-32768, 32767, 65535, 0));
    pending_items.push_back(mk(32767, -32768, 65535, 1));
    pending_items.push_back(mk(1, 2, 3, 0));
    pending_items.push_back(mk(-5, 7, 1, 0));
    pending_items.push_back(mk(9, -4, 65535, 1));
    pending_items.push_back(mk(100, 5, 0, 0));
    pending_items.push_back(mk(-100, 6, 0, 1));
    pending_items.push_back(mk(1234, -777, 42, 1));
    pending_items.push_back(mk(3, 10, 5, 0));
    pending_items.push_back(mk(-8, 10, 9, 1));
    pending_items.push_back(mk(0, 0, 0, 1));
    pending_items.push_back(mk(-1, -1, 1, 0));
    pending_items.push_back(mk(1, 1, 1, 0));
    pending_items.push_back(mk(0, 0, 65535, 1));
    drain();

    // random phases with different sender idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 83 : 0;
      sent = 0;
      while (sent < 595) begin
        push_random_set();
        sent = pending_items.size() + sent;
        wait (pending_items.size() == 0);
      end
      drain();
    end

    wait (!busy);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && corr_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
design/wpc_pkg.sv
design/wpc_mul.sv
design/wpc_root.sv
design/weighted_pearson_correlation.sv
tb/sv/tb.sv
